// ===== hdl/sawc_pkg.sv =====
// Package for the set-associative write-back cache.
// Holds geometry constants, payload structs and the controller state type.
package sawc_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int LINE_WORDS  = 16;
    localparam int SET_BITS    = $clog2(SETS);
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WORD_BITS   = $clog2(LINE_WORDS);
    localparam int OFF_BITS    = WORD_BITS + 2;
    localparam int TAG_LSB     = OFF_BITS + SET_BITS;
    localparam int TAG_BITS    = 32 - TAG_LSB;
    localparam int LINE_BITS   = SET_BITS + WAY_BITS;
    localparam int DATA_BITS   = LINE_BITS + WORD_BITS;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    localparam logic [1:0] KIND_RESP  = 2'd0;
    localparam logic [1:0] KIND_MWR   = 2'd1;
    localparam logic [1:0] KIND_FREQ  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [31:0] write_mask;
        logic [31:0] fill_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mem_address;
        logic [31:0] word_data;
        logic        hit;
        logic        last;
    } t_out;

    // one way of a tag memory entry
    typedef struct packed {
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
    } t_tag_way;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_FREQ,
        ST_WAIT_FILL,
        ST_WB,
        ST_RESP
    } t_state;

endpackage

// ===== hdl/sawc_data_ram.sv =====
// Line data memory of the cache, one 32-bit word per entry.
// Uses sawc_pkg for the address width.
module sawc_data_ram
    import sawc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [DATA_BITS-1:0] i_waddr,
    input  logic [31:0]          i_wdata,
    input  logic [DATA_BITS-1:0] i_raddr,
    output logic [31:0]          o_rdata
);

    logic [31:0] r_mem [SETS*WAYS*LINE_WORDS];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/set_assoc_writeback_cache_top.sv =====
// Top level of the set-associative write-back cache (64 sets x 4 ways x 64 B).
// Uses sawc_pkg and sawc_data_ram.
//
// Usage: raise i_start with a word on i_in while o_busy is low; the word is taken
// on that edge. Results appear one per cycle on o_out, marked by o_valid for one
// cycle; the receiver cannot stall. The result with last set closes the item.
// A hit passes through tag lookup and data read before it answers.
// A miss with a dirty victim streams 16 memory-write words, one per cycle, then
// a fill request; without it the request follows the lookup directly.
// Fill words are then taken one per cycle; after the last, a read answers in the
// next cycle, a write streams 16 merged words and a response.
// No new item is taken until the controller is back in idle: a hit walks
// acceptance, lookup and response.
// Ignored items (access while a fill is pending, stray fill words, action 3)
// produce nothing and leave the controller idle.
// Reset clears valid bits at once (flip-flops per line), the LFSR and the
// controller; dirty flags and tags sit in a per-set tag memory and count only
// for valid lines; data memory is not reset and holds defined words only after being
// written, and a never-written line is never valid, so its contents are never returned.
module set_assoc_writeback_cache_top
    import sawc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_valid,
    output t_out o_out
);

    t_state r_state, n_state;

    // line valid bits in flip-flops
    logic [SETS*WAYS-1:0] r_valid;
    logic [15:0]          r_lfsr;

    // per-set tag memory: dirty flag and tag of every way
    t_tag_way [WAYS-1:0]  r_tag_mem [SETS];
    t_tag_way [WAYS-1:0]  r_tag_rd;
    t_tag_way [WAYS-1:0]  w_tag_wdata;
    logic                 w_tag_we;
    logic [TAG_BITS-1:0]  r_vtag;

    logic                 r_fill_pend;
    logic                 r_is_write;
    logic [31:0]          r_addr, r_data, r_mask;
    logic [WAY_BITS-1:0]  r_way;
    logic [WORD_BITS:0]   r_cnt;
    logic                 r_hit;
    logic                 r_resp_zero;

    logic [SET_BITS-1:0]  w_set;
    logic [TAG_BITS-1:0]  w_tag;
    logic [WORD_BITS-1:0] w_word;
    assign w_set  = r_addr[TAG_LSB-1:OFF_BITS];
    assign w_tag  = r_addr[31:TAG_LSB];
    assign w_word = r_addr[OFF_BITS-1:2];

    logic                 w_acc;
    assign w_acc = i_start && !o_busy;

    // data memory ports
    logic                 w_we;
    logic [DATA_BITS-1:0] w_waddr, w_raddr;
    logic [31:0]          w_wdata, w_rdata;
    logic                 r_fwd;
    logic [31:0]          r_fwd_data;
    logic [31:0]          w_rd;

    sawc_data_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // forward a word written in the cycle it was read
    assign w_rd = r_fwd ? r_fwd_data : w_rdata;

    // tag memory: read the set of the incoming word, write back at lookup
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_set] <= w_tag_wdata;
        end
        r_tag_rd <= r_tag_mem[i_in.address[TAG_LSB-1:OFF_BITS]];
    end

    // tag compare over the set
    logic                hit_any, inv_any;
    logic [WAY_BITS-1:0] hit_way, inv_way;
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_valid[{w_set, WAY_BITS'(w)}] && r_tag_rd[WAY_BITS'(w)].tag == w_tag) begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!r_valid[{w_set, WAY_BITS'(w)}]) begin
                inv_any = 1'b1;
                inv_way = WAY_BITS'(w);
            end
        end
    end

    logic [15:0]         lfsr_nx;
    assign lfsr_nx = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    logic [WAY_BITS-1:0] vic_way;
    assign vic_way = inv_any ? inv_way : WAY_BITS'(lfsr_nx);

    // set entry written back at lookup: mark a write hit dirty, claim the victim on a miss
    always_comb begin
        w_tag_we    = (r_state == ST_LOOKUP);
        w_tag_wdata = r_tag_rd;
        if (hit_any) begin
            if (r_is_write) w_tag_wdata[hit_way].dirty = 1'b1;
        end else begin
            w_tag_wdata[vic_way].dirty = 1'b0;
            w_tag_wdata[vic_way].tag   = w_tag;
        end
    end

    logic [LINE_BITS-1:0] cur_line;
    assign cur_line = {w_set, r_way};

    logic [31:0] merged;
    assign merged = (w_rd & ~r_mask) | (r_data & r_mask);

    // stream step: the read index runs one word ahead of the emitted word
    logic [WORD_BITS-1:0] rd_word;
    assign rd_word = r_cnt[WORD_BITS-1:0];

    // write-miss merge: in the first WB cycle, write merged word at the offset
    logic wb_merge;
    assign wb_merge = (r_state == ST_WB) && r_cnt == '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && !r_fill_pend && (i_in.action == ACT_READ ||
                    i_in.action == ACT_WRITE)) begin
                    n_state = ST_LOOKUP;
                end else if (w_acc && r_fill_pend && i_in.action == ACT_FILL &&
                    r_cnt == (WORD_BITS+1)'(LINE_WORDS - 1)) begin
                    n_state = r_is_write ? ST_WB : ST_RESP;
                end
            end
            ST_LOOKUP: begin
                if (hit_any) begin
                    n_state = ST_RESP;
                end else if (r_valid[{w_set, vic_way}] && r_tag_rd[vic_way].dirty) begin
                    n_state = ST_EVICT;
                end else begin
                    n_state = ST_FREQ;
                end
            end
            ST_EVICT: begin
                if (r_cnt == (WORD_BITS+1)'(LINE_WORDS)) n_state = ST_FREQ;
            end
            ST_FREQ:      n_state = ST_IDLE;
            ST_WAIT_FILL: n_state = ST_IDLE;
            ST_WB: begin
                if (r_cnt == (WORD_BITS+1)'(LINE_WORDS)) n_state = ST_RESP;
            end
            ST_RESP:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_busy   = (r_state != ST_IDLE);
        o_valid  = 1'b0;
        o_out    = '0;
        w_we     = 1'b0;
        w_waddr  = {cur_line, w_word};
        w_wdata  = merged;
        w_raddr  = {cur_line, w_word};
        unique case (r_state)
            ST_IDLE: begin
                // fill word goes straight to memory
                w_we    = w_acc && r_fill_pend && i_in.action == ACT_FILL;
                w_waddr = {cur_line, r_cnt[WORD_BITS-1:0]};
                w_wdata = i_in.fill_data;
            end
            ST_LOOKUP: begin
                w_raddr = hit_any ? {w_set, hit_way, w_word} : {w_set, vic_way, WORD_BITS'(0)};
            end
            ST_EVICT, ST_WB: begin
                w_we    = wb_merge;
                w_raddr = {cur_line, rd_word};
                if (r_cnt != '0) begin
                    o_valid = 1'b1;
                    o_out.kind = KIND_MWR;
                    o_out.word_data = w_rd;
                    if (r_state == ST_EVICT) begin
                        o_out.mem_address = {r_vtag, w_set,
                            WORD_BITS'(r_cnt - 1'b1), 2'b00};
                    end else begin
                        o_out.mem_address = {r_addr[31:OFF_BITS],
                            WORD_BITS'(r_cnt - 1'b1), 2'b00};
                    end
                end
            end
            ST_FREQ: begin
                o_valid = 1'b1;
                o_out.kind = KIND_FREQ;
                o_out.mem_address = {r_addr[31:OFF_BITS], OFF_BITS'(0)};
                o_out.last = 1'b1;
            end
            ST_RESP: begin
                o_valid = 1'b1;
                o_out.kind = KIND_RESP;
                o_out.word_data = r_resp_zero ? 32'd0 : w_rd;
                o_out.hit = r_hit;
                o_out.last = 1'b1;
                // write hit: merge into the word just read
                w_we = r_hit && r_is_write;
            end
            default: ;
        endcase
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_fwd      <= w_we && (w_waddr == w_raddr);
        r_fwd_data <= w_wdata;
        if (w_acc && r_state == ST_IDLE && !r_fill_pend) begin
            r_addr     <= i_in.address;
            r_data     <= i_in.write_data;
            r_mask     <= i_in.write_mask;
            r_is_write <= (i_in.action == ACT_WRITE);
        end
        if (r_state == ST_LOOKUP) begin
            r_hit       <= hit_any;
            r_resp_zero <= hit_any && r_is_write;
            r_way       <= hit_any ? hit_way : vic_way;
            r_vtag      <= r_tag_rd[vic_way].tag;
        end
        if (r_state == ST_IDLE && n_state == ST_RESP) begin
            r_hit       <= 1'b0;
            r_resp_zero <= 1'b0;
        end
        if (r_state == ST_WB && n_state == ST_RESP) begin
            r_hit       <= 1'b0;
            r_resp_zero <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_lfsr      <= LFSR_SEED;
            r_fill_pend <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && r_fill_pend && i_in.action == ACT_FILL) begin
                        if (r_cnt == (WORD_BITS+1)'(LINE_WORDS - 1)) begin
                            r_cnt <= '0;
                            r_fill_pend <= 1'b0;
                            r_valid[cur_line] <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_LOOKUP: begin
                    r_cnt <= (WORD_BITS+1)'(1);
                    if (!hit_any && !inv_any) r_lfsr <= lfsr_nx;
                end
                ST_EVICT: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_FREQ: begin
                    r_valid[cur_line] <= 1'b0;
                    r_fill_pend <= 1'b1;
                    r_cnt <= '0;
                end
                ST_WB: begin
                    r_cnt <= (r_cnt == (WORD_BITS+1)'(LINE_WORDS)) ? '0 : r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/sawc_checker.sv =====
// Port-level checker for the cache top level, bound to it below.
// Uses sawc_pkg for the payload types and codes.
module sawc_checker
    import sawc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input t_out o_out
);

    // result kinds stay in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.kind == KIND_RESP || o_out.kind == KIND_MWR ||
                     o_out.kind == KIND_FREQ))
        else $error("bad result kind");

    // fill requests and responses always close an item
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.kind != KIND_MWR) |-> o_out.last)
        else $error("missing last");

    // memory writes never close an item
    a_mwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.kind == KIND_MWR) |-> !o_out.last)
        else $error("last on memory write");

    // block is idle right after closing an item
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |=> !o_busy)
        else $error("busy after last");

    // nothing is emitted in a cycle that accepts a word
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> !o_valid)
        else $error("result during acceptance");

endmodule

bind set_assoc_writeback_cache_top sawc_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);

// ===== tb/tb.sv =====
// Testbench for the set-associative write-back cache top level.
// Depends on sawc_pkg and set_assoc_writeback_cache_top; predicts every result word.
module tb;
    import sawc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_in;
    logic o_busy;
    logic o_valid;
    t_out o_out;

    set_assoc_writeback_cache_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // Mirror of the cache contents
    logic [0:SETS*WAYS-1]       mdl_valid;
    logic [0:SETS*WAYS-1]       mdl_dirty;
    logic [TAG_BITS-1:0]        mdl_tag   [SETS*WAYS];
    logic [31:0]                mdl_words [SETS*WAYS*LINE_WORDS];
    logic [15:0]                mdl_lfsr;
    logic                       pend_fill;
    logic                       pend_write;
    logic [31:0]                pend_addr;
    logic [31:0]                pend_data;
    logic [31:0]                pend_mask;
    int unsigned                pend_way;
    int unsigned                fill_count;

    t_out expected_words[$];
    int   mismatches;
    int   responses_seen;
    int   idle_cycles;
    int   sender_idle_pct;
    bit   timed_out;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_out make_word(logic [1:0] kind, logic [31:0] addr, logic [31:0] data,
                                       logic hit, logic last);
        t_out w;
        w.kind = kind;
        w.mem_address = addr;
        w.word_data = data;
        w.hit = hit;
        w.last = last;
        return w;
    endfunction

    task automatic push_line(int unsigned line, logic [31:0] base);
        for (int i = 0; i < LINE_WORDS; i++)
            expected_words.push_back(make_word(KIND_MWR, base + 32'(4 * i),
                                               mdl_words[line*LINE_WORDS+i], 1'b0, 1'b0));
    endtask

    // Work out the results of one accepted item and update the mirror
    task automatic predict_cache(t_in it);
        int unsigned set_idx;
        int unsigned woff;
        int unsigned line;
        int unsigned way;
        logic [TAG_BITS-1:0] tg;
        logic bit_in;
        bit found;
        if (pend_fill) begin
            if (it.action != ACT_FILL)
                return;
            set_idx = pend_addr[TAG_LSB-1:OFF_BITS];
            woff = pend_addr[OFF_BITS-1:2];
            line = set_idx * WAYS + pend_way;
            mdl_words[line*LINE_WORDS+fill_count] = it.fill_data;
            if (fill_count + 1 < LINE_WORDS) begin
                fill_count++;
                return;
            end
            fill_count = 0;
            pend_fill = 1'b0;
            mdl_valid[line] = 1'b1;
            mdl_dirty[line] = 1'b0;
            mdl_tag[line] = pend_addr[31:TAG_LSB];
            if (!pend_write) begin
                expected_words.push_back(make_word(KIND_RESP, '0,
                                         mdl_words[line*LINE_WORDS+woff], 1'b0, 1'b1));
                return;
            end
            mdl_words[line*LINE_WORDS+woff] = (mdl_words[line*LINE_WORDS+woff] & ~pend_mask)
                                              | (pend_data & pend_mask);
            push_line(line, {pend_addr[31:OFF_BITS], {OFF_BITS{1'b0}}});
            expected_words.push_back(make_word(KIND_RESP, '0, '0, 1'b0, 1'b1));
            return;
        end
        if (it.action != ACT_READ && it.action != ACT_WRITE)
            return;
        set_idx = it.address[TAG_LSB-1:OFF_BITS];
        woff = it.address[OFF_BITS-1:2];
        tg = it.address[31:TAG_LSB];
        // Hit path
        for (int w = 0; w < WAYS; w++) begin
            line = set_idx * WAYS + w;
            if (mdl_valid[line] && mdl_tag[line] == tg) begin
                if (it.action == ACT_READ) begin
                    expected_words.push_back(make_word(KIND_RESP, '0,
                                             mdl_words[line*LINE_WORDS+woff], 1'b1, 1'b1));
                end else begin
                    mdl_words[line*LINE_WORDS+woff] =
                        (mdl_words[line*LINE_WORDS+woff] & ~it.write_mask)
                        | (it.write_data & it.write_mask);
                    mdl_dirty[line] = 1'b1;
                    expected_words.push_back(make_word(KIND_RESP, '0, '0, 1'b1, 1'b1));
                end
                return;
            end
        end
        // Miss: pick a victim
        found = 1'b0;
        way = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && !mdl_valid[set_idx*WAYS+w]) begin
                way = w;
                found = 1'b1;
            end
        end
        if (!found) begin
            bit_in = mdl_lfsr[0] ^ mdl_lfsr[2] ^ mdl_lfsr[3] ^ mdl_lfsr[5];
            mdl_lfsr = {bit_in, mdl_lfsr[15:1]};
            way = mdl_lfsr % WAYS;
        end
        line = set_idx * WAYS + way;
        if (mdl_valid[line] && mdl_dirty[line])
            push_line(line, {mdl_tag[line], set_idx[SET_BITS-1:0], {OFF_BITS{1'b0}}});
        mdl_valid[line] = 1'b0;
        mdl_dirty[line] = 1'b0;
        pend_fill = 1'b1;
        pend_write = (it.action == ACT_WRITE);
        pend_addr = it.address;
        pend_data = it.write_data;
        pend_mask = it.write_mask;
        pend_way = way;
        fill_count = 0;
        expected_words.push_back(make_word(KIND_FREQ,
                                 {it.address[31:OFF_BITS], {OFF_BITS{1'b0}}}, '0, 1'b0, 1'b1));
    endtask

    // Send one word: optional random gap, then hold start until accepted.
    // Start stays high after acceptance; a gap in the next send or a drain drops it.
    task automatic send_word(t_in it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        predict_cache(it);
    endtask

    // Check every result word against the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", o_out);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out.kind == KIND_RESP)
                    responses_seen++;
                if (o_out !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %p actual %p", exp_w, o_out);
                end
            end
        end
    end

    // Watchdog: count cycles with nothing accepted or emitted
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("set_assoc_writeback_cache_top: mismatch");
            $finish;
        end
    end

    function automatic t_in access_word(logic [1:0] act, logic [31:0] addr);
        t_in it;
        it.action = act;
        it.address = addr;
        it.write_data = $urandom();
        it.write_mask = $urandom();
        it.fill_data = $urandom();
        return it;
    endfunction

    // Feed a full line of fill words
    task automatic fill_line();
        t_in it;
        for (int i = 0; i < LINE_WORDS; i++) begin
            it = access_word(ACT_FILL, $urandom());
            if (i == 0)
                it.fill_data = '1;
            else if (i == 1)
                it.fill_data = '0;
            send_word(it);
        end
    endtask

    // Drop start and hold off until every expected word has come
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Read miss and hits with extreme fields, stray words ignored
    task automatic test_directed();
        t_in it;
        it = access_word(ACT_FILL, '0);
        send_word(it);
        it = access_word(2'd3, '1);
        send_word(it);
        send_word(access_word(ACT_READ, '1));
        send_word(access_word(ACT_WRITE, '0));
        fill_line();
        send_word(access_word(ACT_READ, '1));
        it = access_word(ACT_WRITE, 32'hFFFF_FFFC);
        it.write_data = '1;
        it.write_mask = '1;
        send_word(it);
        it.write_mask = '0;
        send_word(it);
        send_word(access_word(ACT_READ, '1));
        wait_drained();
    endtask

    // Fill the top set past its ways so a dirty line gets evicted
    task automatic test_eviction();
        t_in it;
        for (int n = 0; n < 4; n++) begin
            it = access_word((n % 2 == 0) ? ACT_WRITE : ACT_READ,
                             {20'(n * 7 + 1), 6'd63,
                              (n == 0) ? 6'd0 : 6'($urandom_range(63))});
            send_word(it);
            fill_line();
            it.action = ACT_WRITE;
            send_word(it);
        end
        wait_drained();
    endtask

    // Random accesses over a small address pool to mix hits and misses
    task automatic test_random(int count);
        t_in it;
        logic [31:0] addr;
        addr = '0;
        for (int n = 0; n < count; n++) begin
            if (pend_fill) begin
                if ($urandom_range(9) == 0)
                    it = access_word(2'($urandom_range(3)), $urandom());
                else
                    it = access_word(ACT_FILL, $urandom());
            end else begin
                if ($urandom_range(19) == 0)
                    addr = $urandom();
                else
                    addr = {20'($urandom_range(5)) ^ {20{addr[31]}},
                            6'($urandom_range(3)), 6'($urandom())};
                it = access_word(($urandom_range(1) != 0) ? ACT_WRITE : ACT_READ, addr);
                if ($urandom_range(15) == 0)
                    it.action = 2'($urandom_range(2, 3));
            end
            send_word(it);
            if (n == count / 2)
                wait_drained();
        end
        while (pend_fill)
            send_word(access_word(ACT_FILL, $urandom()));
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        mismatches = 0;
        responses_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        sender_idle_pct = 13;
        mdl_valid = '0;
        mdl_dirty = '0;
        foreach (mdl_tag[i])
            mdl_tag[i] = '0;
        foreach (mdl_words[i])
            mdl_words[i] = '0;
        mdl_lfsr = LFSR_SEED;
        pend_fill = 1'b0;
        pend_write = 1'b0;
        pend_addr = '0;
        pend_data = '0;
        pend_mask = '0;
        pend_way = 0;
        fill_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        sender_idle_pct = 80;
        test_eviction();
        sender_idle_pct = 0;
        test_random(10);

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered read/write hits and misses, dirty evictions and ignored words;");
        $display("%0d responses checked", responses_seen);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("set_assoc_writeback_cache_top: match");
        else
            $display("set_assoc_writeback_cache_top: mismatch");
        $finish;
    end
endmodule
